// ----- rtl/core/fcw_pkg.sv -----
`timescale 1ns / 1ps

package fcw_pkg;

   // table geometry and walk limit
   localparam int TABLE_ENTRIES = 32768;
   localparam int MAX_CLUSTERS  = 64;
   localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(MAX_CLUSTERS + 1);

   // field widths
   localparam int CLU_W   = 16;
   localparam int SPC_W   = 8;
   localparam int BPS_W   = 13;
   localparam int SEC_W   = 32;
   localparam int BYTE_W  = 16;
   localparam int CSIZE_W = SPC_W + BPS_W;
   localparam int PROD_W  = CLU_W + SPC_W;
   localparam int CSR_IDX_W = 2;

   // cluster number limits
   localparam logic [CLU_W-1:0] CHAIN_END_MIN      = 16'hFFF8;
   localparam logic [CLU_W-1:0] FIRST_DATA_CLUSTER = 16'd2;

   // request commands
   localparam logic CMD_TBL_WRITE = 1'b0;
   localparam logic CMD_WALK      = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPC = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BPS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FDS = 2'd2;

   // register reset values
   localparam logic [SPC_W-1:0] SPC_RESET = 8'd1;
   localparam logic [BPS_W-1:0] BPS_RESET = 13'd512;
   localparam logic [SEC_W-1:0] FDS_RESET = 32'd0;

   // controller to datapath
   typedef struct packed {
      logic tbl_wr;
      logic start;
      logic empty;
      logic calc;
      logic form;
      logic advance;
   } fcw_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_ok;
      logic last;
   } fcw_sts_type;

endpackage

// ----- rtl/core/fcw_ctrl.sv -----
`timescale 1ns / 1ps

module fcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_cmd,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  fcw_pkg::fcw_sts_type sts,
   output fcw_pkg::fcw_cmd_type cmd
);
   import fcw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_CALC,
      ST_FORM,
      ST_OUT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      req_beat;
   logic      rsp_beat;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
   assign req_beat  = req_valid & req_ready_ff;
   assign rsp_beat  = rsp_valid_ff & rsp_ready;

   // datapath commands
   always_comb begin
      cmd         = '0;
      cmd.tbl_wr  = (state_ff == ST_IDLE) && req_beat && (req_cmd == CMD_TBL_WRITE);
      cmd.start   = (state_ff == ST_IDLE) && req_beat && (req_cmd == CMD_WALK);
      cmd.empty   = (state_ff == ST_FIRST) && !sts.start_ok;
      cmd.calc    = (state_ff == ST_CALC);
      cmd.form    = (state_ff == ST_FORM);
      cmd.advance = (state_ff == ST_OUT) && rsp_beat && !sts.last;
   end

   // state and handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_beat && (req_cmd == CMD_WALK)) begin
                  state_ff     <= ST_FIRST;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_FIRST: begin
               if (sts.start_ok) begin
                  state_ff <= ST_CALC;
               end else begin
                  state_ff     <= ST_OUT;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_CALC: begin
               state_ff <= ST_FORM;
            end
            ST_FORM: begin
               state_ff     <= ST_OUT;
               rsp_valid_ff <= 1'b1;
            end
            ST_OUT: begin
               if (rsp_beat) begin
                  rsp_valid_ff <= 1'b0;
                  if (sts.last) begin
                     state_ff     <= ST_IDLE;
                     req_ready_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_CALC;
                  end
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

// ----- rtl/core/fcw_dpath.sv -----
`timescale 1ns / 1ps

module fcw_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fcw_pkg::fcw_cmd_type                 cmd,
   output fcw_pkg::fcw_sts_type                 sts,
   input  logic                                 csr_we,
   input  logic [fcw_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fcw_pkg::SEC_W-1:0]            csr_wdata,
   input  logic [14:0]                          req_entry_index,
   input  logic [fcw_pkg::CLU_W-1:0]            req_entry_value,
   input  logic [fcw_pkg::CLU_W-1:0]            req_start_cluster,
   input  logic [31:0]                          req_file_size,
   input  logic [fcw_pkg::BYTE_W-1:0]           req_buffer_size,
   output logic                                 rsp_valid_res,
   output logic [fcw_pkg::CLU_W-1:0]            rsp_cluster,
   output logic [fcw_pkg::SEC_W-1:0]            rsp_sector_address,
   output logic [fcw_pkg::BYTE_W-1:0]           rsp_cluster_bytes,
   output logic [fcw_pkg::BYTE_W-1:0]           rsp_bytes_total,
   output logic                                 rsp_out_of_table,
   output logic                                 rsp_last
);
   import fcw_pkg::*;

   // next-cluster table
   logic [CLU_W-1:0] tbl_mem [TABLE_ENTRIES];
   logic [CLU_W-1:0] rd_ff;

   // configuration
   logic [SPC_W-1:0]   spc_ff;
   logic [BPS_W-1:0]   bps_ff;
   logic [SEC_W-1:0]   fds_ff;
   logic [CSIZE_W-1:0] csize_ff;

   // walk state
   logic [CLU_W-1:0]  cur_ff;
   logic [BYTE_W-1:0] want_ff;
   logic [BYTE_W-1:0] total_ff;
   logic [BYTE_W-1:0] take_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [CNT_W-1:0]  cnt_ff;

   // result register
   logic              valid_res_ff;
   logic [CLU_W-1:0]  cluster_ff;
   logic [SEC_W-1:0]  sector_ff;
   logic [BYTE_W-1:0] bytes_in_ff;
   logic [BYTE_W-1:0] bytes_total_ff;
   logic              oot_ff;
   logic              last_ff;

   // combinational next values
   logic [BYTE_W-1:0] want_in;
   logic [BYTE_W-1:0] remain_in;
   logic [BYTE_W-1:0] take_in;
   logic [SEC_W-1:0]  sector_in;
   logic              more_in;
   logic              oot_in;
   logic              last_in;
   logic              cnt_max_in;
   logic              next_ok_in;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff <= SPC_RESET;
         bps_ff <= BPS_RESET;
         fds_ff <= FDS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPC: spc_ff <= csr_wdata[SPC_W-1:0];
            CSR_BPS: bps_ff <= csr_wdata[BPS_W-1:0];
            CSR_FDS: fds_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // cluster size in bytes, refreshed every cycle
   always_ff @(posedge clock) begin
      csize_ff <= CSIZE_W'(spc_ff) * CSIZE_W'(bps_ff);
   end

   // table write port and registered read port
   always_ff @(posedge clock) begin
      if (cmd.tbl_wr && (32'(req_entry_index) < TABLE_ENTRIES)) begin
         tbl_mem[TBL_AW'(req_entry_index)] <= req_entry_value;
      end
      if (cmd.calc) begin
         rd_ff <= tbl_mem[cur_ff[TBL_AW-1:0]];
      end
   end

   // bytes to read: smaller of file size and buffer size
   assign want_in = (32'(req_buffer_size) < req_file_size) ? req_buffer_size
                                                            : req_file_size[BYTE_W-1:0];

   assign sts.start_ok = (cur_ff >= FIRST_DATA_CLUSTER) && (cur_ff < CHAIN_END_MIN) &&
                         (want_ff != '0);

   // per-cluster byte count
   assign remain_in = want_ff - total_ff;
   assign take_in   = (csize_ff < CSIZE_W'(remain_in)) ? csize_ff[BYTE_W-1:0] : remain_in;

   // end-of-walk decision, taken once the next entry is in hand
   assign sector_in  = fds_ff + SEC_W'(prod_ff);
   assign more_in    = total_ff < want_ff;
   assign oot_in     = more_in && (32'(cur_ff) >= TABLE_ENTRIES);
   assign cnt_max_in = (32'(cnt_ff) == (MAX_CLUSTERS - 1));
   assign next_ok_in = (rd_ff >= FIRST_DATA_CLUSTER) && (rd_ff < CHAIN_END_MIN);
   assign last_in    = !more_in || oot_in || cnt_max_in || !next_ok_in;

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cur_ff   <= req_start_cluster;
         want_ff  <= want_in;
         total_ff <= '0;
         cnt_ff   <= '0;
      end else if (cmd.calc) begin
         take_ff  <= take_in;
         total_ff <= total_ff + take_in;
         prod_ff  <= PROD_W'(cur_ff - FIRST_DATA_CLUSTER) * PROD_W'(spc_ff);
      end else if (cmd.advance) begin
         cur_ff <= rd_ff;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.empty) begin
         valid_res_ff   <= 1'b0;
         cluster_ff     <= '0;
         sector_ff      <= '0;
         bytes_in_ff    <= '0;
         bytes_total_ff <= '0;
         oot_ff         <= 1'b0;
         last_ff        <= 1'b1;
      end else if (cmd.form) begin
         valid_res_ff   <= 1'b1;
         cluster_ff     <= cur_ff;
         sector_ff      <= sector_in;
         bytes_in_ff    <= take_ff;
         bytes_total_ff <= total_ff;
         oot_ff         <= oot_in;
         last_ff        <= last_in;
      end
   end

   assign sts.last = last_ff;

   assign rsp_valid_res      = valid_res_ff;
   assign rsp_cluster        = cluster_ff;
   assign rsp_sector_address = sector_ff;
   assign rsp_cluster_bytes  = bytes_in_ff;
   assign rsp_bytes_total    = bytes_total_ff;
   assign rsp_out_of_table   = oot_ff;
   assign rsp_last           = last_ff;

endmodule

// ----- rtl/core/fat16_cluster_chain_walk.sv -----
`timescale 1ns / 1ps
// Table write (cmd 0): the next request may follow at once.
// Walk (cmd 1): a start check, then per cluster the byte count and table read, result forming
// and the result beat, which waits out any output stall; an empty walk goes from the start
// check straight to its result beat. A walk covers at most 64 clusters.
// Reset (synchronous, active high) clears control and config; the table is not cleared.
module fat16_cluster_chain_walk (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [fcw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fcw_pkg::SEC_W-1:0]          csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_cmd,
   input  logic [14:0]                        req_entry_index,
   input  logic [fcw_pkg::CLU_W-1:0]          req_entry_value,
   input  logic [fcw_pkg::CLU_W-1:0]          req_start_cluster,
   input  logic [31:0]                        req_file_size,
   input  logic [fcw_pkg::BYTE_W-1:0]         req_buffer_size,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_valid_res,
   output logic [fcw_pkg::CLU_W-1:0]          rsp_cluster,
   output logic [fcw_pkg::SEC_W-1:0]          rsp_sector_address,
   output logic [fcw_pkg::BYTE_W-1:0]         rsp_cluster_bytes,
   output logic [fcw_pkg::BYTE_W-1:0]         rsp_bytes_total,
   output logic                               rsp_out_of_table,
   output logic                               rsp_last
);
   import fcw_pkg::*;

   fcw_cmd_type cmd;
   fcw_sts_type sts;

   fcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fcw_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_entry_index    (req_entry_index),
      .req_entry_value    (req_entry_value),
      .req_start_cluster  (req_start_cluster),
      .req_file_size      (req_file_size),
      .req_buffer_size    (req_buffer_size),
      .rsp_valid_res      (rsp_valid_res),
      .rsp_cluster        (rsp_cluster),
      .rsp_sector_address (rsp_sector_address),
      .rsp_cluster_bytes  (rsp_cluster_bytes),
      .rsp_bytes_total    (rsp_bytes_total),
      .rsp_out_of_table   (rsp_out_of_table),
      .rsp_last           (rsp_last)
   );

   // no new request while a walk result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

   // an empty walk result is always the final one
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> rsp_last)
      else $error("empty result without last");

   // a table overrun ends the walk
   a_oot_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_table) |-> rsp_last)
      else $error("out_of_table without last");

   // running total covers this cluster's bytes
   a_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_valid_res) |-> (rsp_bytes_total >= rsp_cluster_bytes))
      else $error("running total below cluster bytes");

   // the final result beat frees the request side
   a_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("request side not released after final beat");

endmodule
